[hdl/rmv_pkg.sv]
// Shared types and constants for the running mean and variance block.
`default_nettype none

package rmv_pkg;

    // Width of the shared unit's wide operand and result.
    localparam int WIDE = 128;
    // Width of the shared unit's narrow operand and remainder.
    localparam int NARROW = 64;
    // Width of the iteration length field.
    localparam int LEN_BITS = 8;
    // Critical value after reset (1.96 in unsigned Q4.12).
    localparam logic [15:0] CV_RESET = 16'd8028;
    // Fraction bits of the critical value.
    localparam int CV_FRAC = 12;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } t_op;

    typedef struct packed {
        logic                start;
        t_op                 op;
        logic [LEN_BITS-1:0] len;
    } t_cmd;

    typedef enum logic [4:0] {
        S_IDLE,
        S_PREP,
        S_ADD_DIV,
        S_ADD_D2,
        S_ADD_MUL,
        S_MG_DD,
        S_MG_Q1MUL,
        S_MG_Q1DIV,
        S_MG_XMUL,
        S_MG_RMUL,
        S_MG_RDIV,
        S_MG_M2A,
        S_MG_M2B,
        S_MG_MMUL,
        S_MG_MDIV,
        S_SUM,
        S_V1,
        S_V2,
        S_SQRT,
        S_HW,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

[hdl/running_mean_variance_ci.sv]
// Top level of the running mean, variance and confidence interval block.
//
//  Channel | Direction | Handshake                  | Payload
//  --------+-----------+----------------------------+----------------------------------------
//  in      | input     | i_in_valid / o_in_stall    | req_type, sample, part_count, part_mean,
//          |           |                            | part_sum_sq
//  out     | output    | o_out_valid / i_out_stall  | total_count, mean_out, std_error,
//          |           |                            | ci_lower, ci_upper, summary_valid
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | critical value (unsigned Q4.12)
//
// Each transaction runs through one shared multiply/divide/square-root unit under the
// sequencer below, one bit (two radicand bits for the root) per cycle. The summary (variance,
// standard error and interval) is computed only when the count is at least two.
// Reset (synchronous, active low) clears the statistics and loads 1.96 as critical value.
// o_in_stall is high from acceptance until the result is loaded into the output register;
// a stalled output holds its result and the next transaction can already be taken.
`default_nettype none

module running_mean_variance_ci import rmv_pkg::*; #(
    parameter int COUNT_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_req_type,
    input  wire logic [31:0] i_sample,
    input  wire logic [31:0] i_part_count,
    input  wire logic [31:0] i_part_mean,
    input  wire logic [62:0] i_part_sum_sq,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_total_count,
    output logic [31:0]      o_mean_out,
    output logic [31:0]      o_std_error,
    output logic [31:0]      o_ci_lower,
    output logic [31:0]      o_ci_upper,
    output logic             o_summary_valid,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data
);

    localparam int CB = COUNT_BITS;
    localparam logic [63:0] CNT_MAX64 = (64'd1 << COUNT_BITS) - 64'd1;

    // Iteration lengths, chosen so that every operand fits the bits walked.
    localparam logic [LEN_BITS-1:0] LEN_DMAG  = LEN_BITS'(33);
    localparam logic [LEN_BITS-1:0] LEN_ADDQ  = LEN_BITS'(34);
    localparam logic [LEN_BITS-1:0] LEN_CNT   = LEN_BITS'(COUNT_BITS);
    localparam logic [LEN_BITS-1:0] LEN_Q1    = LEN_BITS'(64 + COUNT_BITS);
    localparam logic [LEN_BITS-1:0] LEN_R1    = LEN_BITS'(2 * COUNT_BITS + 2);
    localparam logic [LEN_BITS-1:0] LEN_MSTEP = LEN_BITS'(34 + COUNT_BITS);
    localparam logic [LEN_BITS-1:0] LEN_VAR   = LEN_BITS'(64 + FRAC_BITS);
    localparam logic [LEN_BITS-1:0] LEN_SQRT  = LEN_BITS'(32);
    localparam logic [LEN_BITS-1:0] LEN_CV    = LEN_BITS'(16);

    t_state r_state;
    t_state n_state;
    logic   r_issued;

    // Statistics and configuration.
    logic [CB-1:0] r_count;
    logic [31:0]   r_mean;
    logic [63:0]   r_m2;
    logic [15:0]   r_cv;

    // Captured transaction.
    logic          r_type;
    logic [31:0]   r_sample;
    logic [CB-1:0] r_n2;
    logic [31:0]   r_pm;
    logic [62:0]   r_pss;

    // Working values.
    logic [CB:0]   r_n;
    logic          r_dneg;
    logic [32:0]   r_dmag;
    logic [63:0]   r_t1;
    logic [63:0]   r_t2;
    logic [63:0]   r_t3;
    logic [127:0]  r_x;
    logic [127:0]  r_y;
    logic [31:0]   r_se;
    logic [35:0]   r_hw;
    logic          r_sumv;

    // Output register.
    logic          r_ovalid;
    logic [31:0]   r_o_count;
    logic [31:0]   r_o_mean;
    logic [31:0]   r_o_se;
    logic [31:0]   r_o_lo;
    logic [31:0]   r_o_hi;
    logic          r_o_sv;

    // Shared unit.
    t_cmd          w_cmd;
    logic [127:0]  w_a;
    logic [63:0]   w_b;
    logic          u_done;
    logic [127:0]  u_res;
    logic [63:0]   u_rem;

    logic          w_in_acc;
    logic          w_out_free;

    // Combinational helpers.
    logic [63:0]   w_pc64;
    logic [CB-1:0] w_n2_sat;
    logic [CB:0]   w_n_inc;
    logic [32:0]   w_d_add;
    logic [32:0]   w_d_mg;
    logic          w_rnd;
    logic [33:0]   w_step;
    logic [34:0]   w_mean_new;
    logic [CB-1:0] w_n_sat;
    logic [32:0]   w_d2;
    logic [64:0]   w_sum_a;
    logic [64:0]   w_sum_b;
    logic [63:0]   w_term;
    logic [63:0]   w_cnt64;
    logic [37:0]   w_lo;
    logic [37:0]   w_hi;
    logic [31:0]   w_lo_sat;
    logic [31:0]   w_hi_sat;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_ovalid || !i_out_stall;

    always_comb begin
        // Partial count clipped to the count range.
        w_pc64   = 64'(i_part_count);
        w_n2_sat = (w_pc64 > CNT_MAX64) ? CNT_MAX64[CB-1:0] : w_pc64[CB-1:0];
        // Count after an add, holding at the maximum.
        w_n_inc  = (64'(r_count) < CNT_MAX64) ? ({1'b0, r_count} + 1'b1) : {1'b0, r_count};
        w_d_add  = {r_sample[31], r_sample} - {r_mean[31], r_mean};
        w_d_mg   = {r_pm[31], r_pm} - {r_mean[31], r_mean};
        // Mean step: quotient rounded to nearest, ties away from zero.
        w_rnd    = ({u_rem[CB:0], 1'b0} >= {1'b0, r_n});
        w_step   = u_res[33:0] + 34'(w_rnd);
        if (r_dneg) begin
            w_mean_new = {{3{r_mean[31]}}, r_mean} - {1'b0, w_step};
        end else begin
            w_mean_new = {{3{r_mean[31]}}, r_mean} + {1'b0, w_step};
        end
        w_n_sat  = r_n[CB] ? CNT_MAX64[CB-1:0] : r_n[CB-1:0];
        w_d2     = {r_sample[31], r_sample} - {r_mean[31], r_mean};
        w_sum_a  = {1'b0, r_m2} + {2'b00, r_pss};
        // Merge correction term with saturation above 64 bits.
        w_term   = ((r_x >> (64 + FRAC_BITS)) != '0) ? '1 : 64'(r_x >> FRAC_BITS);
        if (r_state == S_ADD_MUL) begin
            w_sum_b = {1'b0, r_m2} + {1'b0, (u_res[63:0] >> FRAC_BITS)};
        end else begin
            w_sum_b = {1'b0, r_m2} + {1'b0, w_term};
        end
        w_cnt64  = 64'(r_count);
        w_lo     = {{6{r_mean[31]}}, r_mean} - {2'b00, r_hw};
        w_hi     = {{6{r_mean[31]}}, r_mean} + {2'b00, r_hw};
        if (w_lo[37] && !(&w_lo[36:31])) begin
            w_lo_sat = 32'h8000_0000;
        end else if (!w_lo[37] && (|w_lo[36:31])) begin
            w_lo_sat = 32'h7FFF_FFFF;
        end else begin
            w_lo_sat = w_lo[31:0];
        end
        if (!w_hi[37] && (|w_hi[36:31])) begin
            w_hi_sat = 32'h7FFF_FFFF;
        end else if (w_hi[37] && !(&w_hi[36:31])) begin
            w_hi_sat = 32'h8000_0000;
        end else begin
            w_hi_sat = w_hi[31:0];
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                if (!r_type) begin
                    n_state = S_ADD_DIV;
                end else if (r_n2 == '0 || r_count == '0) begin
                    n_state = S_SUM;
                end else begin
                    n_state = S_MG_DD;
                end
            end
            S_ADD_DIV:  if (u_done) n_state = S_ADD_D2;
            S_ADD_D2:   n_state = S_ADD_MUL;
            S_ADD_MUL:  if (u_done) n_state = S_SUM;
            S_MG_DD:    if (u_done) n_state = S_MG_Q1MUL;
            S_MG_Q1MUL: if (u_done) n_state = S_MG_Q1DIV;
            S_MG_Q1DIV: if (u_done) n_state = S_MG_XMUL;
            S_MG_XMUL:  if (u_done) n_state = S_MG_RMUL;
            S_MG_RMUL:  if (u_done) n_state = S_MG_RDIV;
            S_MG_RDIV:  if (u_done) n_state = S_MG_M2A;
            S_MG_M2A:   n_state = S_MG_M2B;
            S_MG_M2B:   n_state = S_MG_MMUL;
            S_MG_MMUL:  if (u_done) n_state = S_MG_MDIV;
            S_MG_MDIV:  if (u_done) n_state = S_SUM;
            S_SUM: begin
                if (w_cnt64 >= 64'd2) begin
                    n_state = S_V1;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_V1: if (u_done) n_state = S_V2;
            S_V2: begin
                if (u_done) begin
                    if (u_res[127:64] != '0) begin
                        n_state = S_HW;
                    end else begin
                        n_state = S_SQRT;
                    end
                end
            end
            S_SQRT: if (u_done) n_state = S_HW;
            S_HW:   if (u_done) n_state = S_OUT;
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands to the shared unit; each operation state starts it once.
    always_comb begin
        w_cmd.start = 1'b0;
        w_cmd.op    = OP_MUL;
        w_cmd.len   = LEN_CNT;
        w_a         = '0;
        w_b         = '0;
        case (r_state)
            S_ADD_DIV: begin
                w_cmd.start = !r_issued;
                w_cmd.op    = OP_DIV;
                w_cmd.len   = LEN_ADDQ;
                w_a         = 128'(r_dmag);
                w_b         = 64'(r_n);
            end
            S_ADD_MUL: begin
                w_cmd.start = !r_issued;
                w_cmd.len   = LEN_DMAG;
                w_a         = 128'(r_dmag);
                w_b         = r_t1;
            end
            S_MG_DD: begin
                w_cmd.start = !r_issued;
                w_cmd.len   = LEN_DMAG;
                w_a         = 128'(r_dmag);
                w_b         = 64'(r_dmag);
            end
            S_MG_Q1MUL: begin
                w_cmd.start = !r_issued;
                w_a         = 128'(r_t1);
                w_b         = 64'(r_count);
            end
            S_MG_Q1DIV: begin
                w_cmd.start = !r_issued;
                w_cmd.op    = OP_DIV;
                w_cmd.len   = LEN_Q1;
                w_a         = r_x;
                w_b         = 64'(r_n);
            end
            S_MG_XMUL: begin
                w_cmd.start = !r_issued;
                w_a         = 128'(r_t2);
                w_b         = 64'(r_n2);
            end
            S_MG_RMUL: begin
                w_cmd.start = !r_issued;
                w_a         = 128'(r_t3);
                w_b         = 64'(r_n2);
            end
            S_MG_RDIV: begin
                w_cmd.start = !r_issued;
                w_cmd.op    = OP_DIV;
                w_cmd.len   = LEN_R1;
                w_a         = r_y;
                w_b         = 64'(r_n);
            end
            S_MG_MMUL: begin
                w_cmd.start = !r_issued;
                w_a         = 128'(r_dmag);
                w_b         = 64'(r_n2);
            end
            S_MG_MDIV: begin
                w_cmd.start = !r_issued;
                w_cmd.op    = OP_DIV;
                w_cmd.len   = LEN_MSTEP;
                w_a         = r_y;
                w_b         = 64'(r_n);
            end
            S_V1: begin
                w_cmd.start = !r_issued;
                w_cmd.op    = OP_DIV;
                w_cmd.len   = LEN_VAR;
                w_a         = 128'(r_m2) << FRAC_BITS;
                w_b         = 64'(r_count) - 64'd1;
            end
            S_V2: begin
                w_cmd.start = !r_issued;
                w_cmd.op    = OP_DIV;
                w_cmd.len   = LEN_VAR;
                w_a         = r_x;
                w_b         = 64'(r_count);
            end
            S_SQRT: begin
                w_cmd.start = !r_issued;
                w_cmd.op    = OP_SQRT;
                w_cmd.len   = LEN_SQRT;
                w_a         = 128'(r_t1);
            end
            S_HW: begin
                w_cmd.start = !r_issued;
                w_cmd.len   = LEN_CV;
                w_a         = 128'(r_se);
                w_b         = 64'(r_cv);
            end
            default: begin
                w_cmd.start = 1'b0;
            end
        endcase
    end

    rmv_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_done  (u_done),
        .o_res   (u_res),
        .o_rem   (u_rem)
    );

    // Control and statistics registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_issued <= 1'b0;
            r_count  <= '0;
            r_mean   <= '0;
            r_m2     <= '0;
            r_cv     <= CV_RESET;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cmd.start) begin
                r_issued <= 1'b1;
            end else if (u_done) begin
                r_issued <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_cv <= i_cfg_data;
            end
            // A new result is loaded as soon as the output register is free.
            if (r_state == S_OUT && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_PREP: begin
                    // An empty block takes a nonempty partial as it is.
                    if (r_type && r_n2 != '0 && r_count == '0) begin
                        r_count <= r_n2;
                        r_mean  <= r_pm;
                        r_m2    <= {1'b0, r_pss};
                    end
                end
                S_ADD_DIV: begin
                    if (u_done) begin
                        r_count <= r_n[CB-1:0];
                        r_mean  <= w_mean_new[31:0];
                    end
                end
                S_ADD_MUL: begin
                    if (u_done) begin
                        r_m2 <= w_sum_b[64] ? '1 : w_sum_b[63:0];
                    end
                end
                S_MG_M2A: r_m2 <= w_sum_a[64] ? '1 : w_sum_a[63:0];
                S_MG_M2B: r_m2 <= w_sum_b[64] ? '1 : w_sum_b[63:0];
                S_MG_MDIV: begin
                    if (u_done) begin
                        r_count <= w_n_sat;
                        r_mean  <= w_mean_new[31:0];
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload and working registers.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_type   <= i_req_type;
            r_sample <= i_sample;
            r_n2     <= w_n2_sat;
            r_pm     <= i_part_mean;
            r_pss    <= i_part_sum_sq;
        end
        case (r_state)
            S_PREP: begin
                if (!r_type) begin
                    r_n    <= w_n_inc;
                    r_dneg <= w_d_add[32];
                    r_dmag <= w_d_add[32] ? (33'd0 - w_d_add) : w_d_add;
                end else begin
                    r_n    <= {1'b0, r_count} + {1'b0, r_n2};
                    r_dneg <= w_d_mg[32];
                    r_dmag <= w_d_mg[32] ? (33'd0 - w_d_mg) : w_d_mg;
                end
            end
            S_ADD_D2: r_t1 <= 64'(w_d2[32] ? (33'd0 - w_d2) : w_d2);
            S_MG_DD:    if (u_done) r_t1 <= u_res[63:0];
            S_MG_Q1MUL: if (u_done) r_x <= u_res;
            S_MG_Q1DIV: begin
                if (u_done) begin
                    r_t2 <= u_res[63:0];
                    r_t3 <= u_rem;
                end
            end
            S_MG_XMUL:  if (u_done) r_x <= u_res;
            S_MG_RMUL:  if (u_done) r_y <= u_res;
            S_MG_RDIV:  if (u_done) r_x <= r_x + u_res;
            S_MG_MMUL:  if (u_done) r_y <= u_res;
            S_SUM: begin
                r_sumv <= (w_cnt64 >= 64'd2);
            end
            S_V1: if (u_done) r_x <= u_res;
            S_V2: begin
                if (u_done) begin
                    r_t1 <= u_res[63:0];
                    if (u_res[127:64] != '0) begin
                        r_se <= '1;
                    end
                end
            end
            S_SQRT: if (u_done) r_se <= u_res[31:0];
            S_HW:   if (u_done) r_hw <= 36'(u_res >> CV_FRAC);
            S_OUT: begin
                if (w_out_free) begin
                    r_o_count <= (w_cnt64 > 64'hFFFF_FFFF) ? '1 : w_cnt64[31:0];
                    r_o_mean  <= r_mean;
                    r_o_se    <= r_sumv ? r_se : '0;
                    r_o_lo    <= r_sumv ? w_lo_sat : '0;
                    r_o_hi    <= r_sumv ? w_hi_sat : '0;
                    r_o_sv    <= r_sumv;
                end
            end
            default: begin
                r_sumv <= r_sumv;
            end
        endcase
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_out_valid     = r_ovalid;
    assign o_total_count   = r_o_count;
    assign o_mean_out      = r_o_mean;
    assign o_std_error     = r_o_se;
    assign o_ci_lower      = r_o_lo;
    assign o_ci_upper      = r_o_hi;
    assign o_summary_valid = r_o_sv;

endmodule

`default_nettype wire

[hdl/rmv_unit.sv]
// Shared iterative unit: shift-add multiply, restoring divide and integer square root.
`default_nettype none

module rmv_unit import rmv_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    input  wire logic [WIDE-1:0]   i_a,
    input  wire logic [NARROW-1:0] i_b,
    output logic                   o_done,
    output logic [WIDE-1:0]        o_res,
    output logic [NARROW-1:0]      o_rem
);

    logic                r_busy;
    logic                r_done;
    t_op                 r_op;
    logic [LEN_BITS-1:0] r_cnt;
    logic [WIDE-1:0]     r_acc;
    logic [WIDE-1:0]     r_aux;
    logic [NARROW-1:0]   r_b;
    logic [NARROW-1:0]   r_rem;
    logic [31:0]         r_root;

    logic [NARROW:0]     w_x;
    logic [NARROW:0]     w_y;
    logic [NARROW+1:0]   w_diff;
    logic                w_ge;

    // One subtractor serves both the divide and the square root steps.
    always_comb begin
        if (r_op == OP_SQRT) begin
            w_x = {1'b0, r_rem[NARROW-3:0], r_acc[63:62]};
            w_y = {1'b0, 30'd0, r_root, 2'b01};
        end else begin
            w_x = {r_rem, r_acc[WIDE-1]};
            w_y = {1'b0, r_b};
        end
        w_diff = {1'b0, w_x} - {1'b0, w_y};
        w_ge   = ~w_diff[NARROW+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= OP_MUL;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_op   <= i_cmd.op;
                r_cnt  <= i_cmd.len;
                case (i_cmd.op)
                    OP_MUL: begin
                        r_acc <= '0;
                        r_aux <= i_a;
                        r_b   <= i_b;
                    end
                    OP_DIV: begin
                        r_acc <= i_a << (LEN_BITS'(WIDE) - i_cmd.len);
                        r_rem <= '0;
                        r_b   <= i_b;
                    end
                    OP_SQRT: begin
                        r_acc  <= i_a;
                        r_rem  <= '0;
                        r_root <= '0;
                    end
                    default: begin
                        r_acc <= '0;
                    end
                endcase
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == LEN_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                case (r_op)
                    OP_MUL: begin
                        if (r_b[0]) begin
                            r_acc <= r_acc + r_aux;
                        end
                        r_aux <= r_aux << 1;
                        r_b   <= r_b >> 1;
                    end
                    OP_DIV: begin
                        if (w_ge) begin
                            r_rem <= w_diff[NARROW-1:0];
                        end else begin
                            r_rem <= w_x[NARROW-1:0];
                        end
                        r_acc <= {r_acc[WIDE-2:0], w_ge};
                    end
                    OP_SQRT: begin
                        if (w_ge) begin
                            r_rem <= w_diff[NARROW-1:0];
                        end else begin
                            r_rem <= w_x[NARROW-1:0];
                        end
                        r_root <= {r_root[30:0], w_ge};
                        r_acc  <= r_acc << 2;
                    end
                    default: begin
                        r_busy <= 1'b0;
                    end
                endcase
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = (r_op == OP_SQRT) ? WIDE'(r_root) : r_acc;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire
